[rtl/stwq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwq_pkg
// types and constants shared by the sorted timer wake queue
// ----------------------------------------------------------------------------
package stwq_pkg;

  localparam int ID_W       = 4;
  localparam int ID_SPACE   = 16;
  localparam int TIME_W     = 32;
  localparam int STEP_W     = 10;
  localparam int KIND_W     = 2;
  localparam int TASKS_DEF  = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SLEEP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WAKE   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] delay;
  } in_req_t;

  typedef struct packed {
    logic [ID_W-1:0] released_task;
    logic            last;
  } out_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] wake;
  } slot_t;

endpackage

[rtl/sorted_timer_wake_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_wake_queue
// millisecond timer with a queue of sleeping tasks sorted by wake time
// ----------------------------------------------------------------------------
// The queue lives in a one-read, one-write memory of TASKS slots, kept sorted
// by wake time, and a small sequencer walks it one slot access at a time
// through a single compare unit. One request is taken at a time; in_stall is
// high until the walk for the previous request ends. A cancel or wake scans
// to the task, then closes the gap; a sleep does an optional removal, scans
// for the insert point and opens a gap; a tick reads the front entry and
// closes the gap at the front for every task it releases. Each memory read
// is followed by a separate check or write state because read data is
// registered. Releases leave through an output register; a stalled output
// holds the walk.
// ----------------------------------------------------------------------------
module sorted_timer_wake_queue #(
  parameter int TASKS = stwq_pkg::TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  stwq_pkg::in_req_t             in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output stwq_pkg::out_rsp_t            out_rsp,
  input  logic                          cfg_we,
  input  logic [stwq_pkg::STEP_W-1:0]   cfg_wdata
);

  localparam int SLOT_W = $clog2(TASKS);
  localparam int CNT_W  = $clog2(TASKS + 1);
  localparam int SLOT_BITS = $bits(stwq_pkg::slot_t);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_FIND_RD  = 4'd1;
  localparam logic [3:0] ST_FIND_CHK = 4'd2;
  localparam logic [3:0] ST_SHL_RD   = 4'd3;
  localparam logic [3:0] ST_SHL_WR   = 4'd4;
  localparam logic [3:0] ST_INS_RD   = 4'd5;
  localparam logic [3:0] ST_INS_CHK  = 4'd6;
  localparam logic [3:0] ST_SHR_RD   = 4'd7;
  localparam logic [3:0] ST_SHR_WR   = 4'd8;
  localparam logic [3:0] ST_TICK_RD  = 4'd9;
  localparam logic [3:0] ST_TICK_CHK = 4'd10;
  localparam logic [3:0] ST_EMIT     = 4'd11;

  logic [3:0]                      state_r, state_nxt;
  logic [stwq_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [stwq_pkg::TIME_W-1:0]     now_r, now_nxt;
  logic [stwq_pkg::TIME_W-1:0]     wake_r, wake_nxt;
  logic [stwq_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [stwq_pkg::ID_W-1:0]       id_r, id_nxt;
  logic [CNT_W-1:0]                occ_r, occ_nxt;
  logic [CNT_W-1:0]                idx_r, idx_nxt;
  logic [CNT_W-1:0]                j_r, j_nxt;
  logic [stwq_pkg::ID_SPACE-1:0]   queued_r, queued_nxt;
  logic                            pend_r, pend_nxt;
  logic                            out_valid_r, out_valid_nxt;
  stwq_pkg::out_rsp_t              out_rsp_r, out_rsp_nxt;

  logic                            ram_we, ram_re;
  logic [SLOT_W-1:0]               ram_waddr, ram_raddr;
  stwq_pkg::slot_t                 ram_wdata, ram_rdata;

  logic                            out_free;
  logic                            wake_le;
  logic                            id_ok;
  logic [CNT_W:0]                  idx_inc;

  stwq_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (TASKS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign id_ok     = (int'(in_req.task_id) < TASKS);
  assign idx_inc   = {1'b0, idx_r} + {{CNT_W{1'b0}}, 1'b1};

  // shared compare unit: slot wake time against the key
  always_comb begin
    if (state_r == ST_TICK_CHK) begin
      wake_le = (ram_rdata.wake <= now_r);
    end else begin
      wake_le = (ram_rdata.wake <= wake_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    now_nxt       = now_r;
    wake_nxt      = wake_r;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    queued_nxt    = queued_r;
    pend_nxt      = pend_r;
    out_rsp_nxt   = out_rsp_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[SLOT_W-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[SLOT_W-1:0];

    if (cfg_we) begin
      step_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_req.kind;
          id_nxt   = in_req.task_id;
          idx_nxt  = '0;
          wake_nxt = now_r + in_req.delay;
          if (in_req.kind == stwq_pkg::KIND_TICK) begin
            now_nxt   = now_r + {{(stwq_pkg::TIME_W - stwq_pkg::STEP_W){1'b0}}, step_r};
            pend_nxt  = 1'b0;
            state_nxt = ST_TICK_RD;
          end else if (id_ok) begin
            if (queued_r[in_req.task_id]) begin
              state_nxt = ST_FIND_RD;
            end else if (in_req.kind == stwq_pkg::KIND_SLEEP) begin
              state_nxt = ST_INS_RD;
            end
          end
        end
      end

      ST_FIND_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_FIND_CHK;
      end

      ST_FIND_CHK: begin
        if (ram_rdata.task_id == id_r || idx_inc >= {1'b0, occ_r}) begin
          state_nxt = ST_SHL_RD;
        end else begin
          idx_nxt   = idx_inc[CNT_W-1:0];
          state_nxt = ST_FIND_RD;
        end
      end

      ST_SHL_RD: begin
        if (idx_inc < {1'b0, occ_r}) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[SLOT_W-1:0];
          state_nxt = ST_SHL_WR;
        end else begin
          occ_nxt          = occ_r - {{(CNT_W-1){1'b0}}, 1'b1};
          queued_nxt[id_r] = 1'b0;
          idx_nxt          = '0;
          case (kind_r)
            stwq_pkg::KIND_TICK:  state_nxt = ST_TICK_RD;
            stwq_pkg::KIND_SLEEP: state_nxt = ST_INS_RD;
            stwq_pkg::KIND_WAKE:  state_nxt = ST_EMIT;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SHL_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_inc[CNT_W-1:0];
        state_nxt = ST_SHL_RD;
      end

      ST_INS_RD: begin
        if (occ_r >= CNT_W'(TASKS)) begin
          state_nxt = ST_IDLE;
        end else if (idx_r < occ_r) begin
          ram_re    = 1'b1;
          state_nxt = ST_INS_CHK;
        end else begin
          j_nxt     = occ_r;
          state_nxt = ST_SHR_RD;
        end
      end

      ST_INS_CHK: begin
        if (wake_le) begin
          idx_nxt   = idx_inc[CNT_W-1:0];
          state_nxt = ST_INS_RD;
        end else begin
          j_nxt     = occ_r;
          state_nxt = ST_SHR_RD;
        end
      end

      ST_SHR_RD: begin
        if (j_r > idx_r) begin
          ram_re    = 1'b1;
          ram_raddr = SLOT_W'(j_r - {{(CNT_W-1){1'b0}}, 1'b1});
          state_nxt = ST_SHR_WR;
        end else begin
          ram_we            = 1'b1;
          ram_wdata.task_id = id_r;
          ram_wdata.wake    = wake_r;
          occ_nxt           = occ_r + {{(CNT_W-1){1'b0}}, 1'b1};
          queued_nxt[id_r]  = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      ST_SHR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[SLOT_W-1:0];
        j_nxt     = j_r - {{(CNT_W-1){1'b0}}, 1'b1};
        state_nxt = ST_SHR_RD;
      end

      ST_TICK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = ST_TICK_CHK;
      end

      ST_TICK_CHK: begin
        // hold a release until the next front entry shows whether it is last
        if (!pend_r || out_free) begin
          if (pend_r) begin
            out_valid_nxt             = 1'b1;
            out_rsp_nxt.released_task = id_r;
            out_rsp_nxt.last          = !(occ_r != '0 && wake_le);
          end
          if (occ_r != '0 && wake_le) begin
            pend_nxt  = 1'b1;
            id_nxt    = ram_rdata.task_id;
            idx_nxt   = '0;
            state_nxt = ST_SHL_RD;
          end else begin
            pend_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_rsp_nxt.released_task = id_r;
          out_rsp_nxt.last          = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= stwq_pkg::STEP_RESET;
      now_r       <= '0;
      occ_r       <= '0;
      queued_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      now_r       <= now_nxt;
      occ_r       <= occ_nxt;
      queued_r    <= queued_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wake_r    <= wake_nxt;
    kind_r    <= kind_nxt;
    id_r      <= id_nxt;
    idx_r     <= idx_nxt;
    j_r       <= j_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule

[rtl/stwq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwq_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module stwq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sorted timer wake queue
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty tick, wake and cancel
// of idle tasks, ties, re-sleep, wrap of the wake time, and a zero, full-scale
// and low-end tick_step. Random phases follow, each under its own tick_step,
// with short and wrapping sleeps, full-queue bursts, random input gaps and
// output backpressure. Every release is checked in order against the row's
// own expectation for typed rows, else against a wake-queue model in the bench.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 52;

  typedef struct {
    bit                          is_cfg;
    logic [stwq_pkg::STEP_W-1:0] step;
    stwq_pkg::in_req_t           req;
    bit                          typed;
    bit                          typed_hit;
    stwq_pkg::out_rsp_t          typed_rsp;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  stwq_pkg::in_req_t  in_req = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  stwq_pkg::out_rsp_t out_rsp;
  logic               cfg_we = 1'b0;
  logic [stwq_pkg::STEP_W-1:0] cfg_wdata = '0;

  // wake queue model
  logic [stwq_pkg::TIME_W-1:0] model_now;
  logic [stwq_pkg::STEP_W-1:0] model_step;
  logic [stwq_pkg::ID_W-1:0]   slot_id [stwq_pkg::ID_SPACE];
  logic [stwq_pkg::TIME_W-1:0] slot_wake_ms [stwq_pkg::ID_SPACE];
  int                          slot_count;
  bit                          is_queued [stwq_pkg::ID_SPACE];

  stwq_pkg::out_rsp_t due_now[$];
  stwq_pkg::out_rsp_t release_q[$];
  plan_row_t          plan[$];

  int  mismatch_count = 0;
  int  req_sent = 0;
  int  rsp_seen = 0;
  int  cfg_writes = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  sorted_timer_wake_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d releases pending", cycle_count,
               release_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 34);
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    stwq_pkg::out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      rsp_seen++;
      if (release_q.size() == 0) begin
        report_mismatch($sformatf("release of task %0d with nothing pending",
                                  out_rsp.released_task));
      end else begin
        want = release_q.pop_front();
        if (out_rsp.released_task !== want.released_task) begin
          report_mismatch($sformatf("released_task %0d, want %0d",
                                    out_rsp.released_task, want.released_task));
        end
        if (out_rsp.last !== want.last) begin
          report_mismatch($sformatf("last %0b on task %0d, want %0b",
                                    out_rsp.last, out_rsp.released_task, want.last));
        end
      end
    end
  end

  // model helpers
  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < slot_count; i++) begin
      slot_id[i]      = slot_id[i + 1];
      slot_wake_ms[i] = slot_wake_ms[i + 1];
    end
    if (slot_count > 0) slot_count--;
  endfunction

  function automatic bit unqueue(input logic [stwq_pkg::ID_W-1:0] id);
    if (!is_queued[id]) return 1'b0;
    for (int i = 0; i < slot_count; i++) begin
      if (slot_id[i] == id) begin
        drop_entry(i);
        break;
      end
    end
    is_queued[id] = 1'b0;
    return 1'b1;
  endfunction

  function automatic void enqueue(input logic [stwq_pkg::ID_W-1:0] id,
                                  input logic [stwq_pkg::TIME_W-1:0] wake);
    int pos;
    pos = 0;
    if (slot_count >= stwq_pkg::ID_SPACE) return;
    while (pos < slot_count && slot_wake_ms[pos] <= wake) pos++;
    for (int i = slot_count; i > pos; i--) begin
      slot_id[i]      = slot_id[i - 1];
      slot_wake_ms[i] = slot_wake_ms[i - 1];
    end
    slot_id[pos]      = id;
    slot_wake_ms[pos] = wake;
    slot_count++;
    is_queued[id] = 1'b1;
  endfunction

  // fills due_now with the releases one request causes
  function automatic void advance_model(input stwq_pkg::in_req_t r);
    stwq_pkg::out_rsp_t rsp;
    due_now.delete();
    case (r.kind)
      stwq_pkg::KIND_TICK: begin
        model_now = model_now + model_step;
        while (slot_count > 0 && slot_wake_ms[0] <= model_now) begin
          rsp.released_task = slot_id[0];
          rsp.last = 1'b0;
          is_queued[slot_id[0]] = 1'b0;
          drop_entry(0);
          due_now.push_back(rsp);
        end
        if (due_now.size() > 0) due_now[due_now.size() - 1].last = 1'b1;
      end
      stwq_pkg::KIND_SLEEP: begin
        void'(unqueue(r.task_id));
        enqueue(r.task_id, model_now + r.delay);
      end
      stwq_pkg::KIND_CANCEL: begin
        void'(unqueue(r.task_id));
      end
      default: begin
        if (unqueue(r.task_id)) begin
          rsp.released_task = r.task_id;
          rsp.last = 1'b1;
          due_now.push_back(rsp);
        end
      end
    endcase
  endfunction

  function automatic plan_row_t req_row(input logic [stwq_pkg::KIND_W-1:0] kind,
                                        input int id,
                                        input logic [stwq_pkg::TIME_W-1:0] dly,
                                        input bit typed = 1'b0,
                                        input bit hit = 1'b0, input int rel = 0);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.step = '0;
    row.req.kind = kind;
    row.req.task_id = stwq_pkg::ID_W'(id);
    row.req.delay = dly;
    row.typed = typed;
    row.typed_hit = hit;
    row.typed_rsp.released_task = stwq_pkg::ID_W'(rel);
    row.typed_rsp.last = 1'b1;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [stwq_pkg::STEP_W-1:0] step);
    plan_row_t row;
    row = req_row(stwq_pkg::KIND_TICK, 0, '0);
    row.is_cfg = 1'b1;
    row.step = step;
    return row;
  endfunction

  task automatic idle_cycle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic issue_request(input stwq_pkg::in_req_t r, input bit typed = 1'b0,
                               input bit hit = 1'b0,
                               input stwq_pkg::out_rsp_t typed_rsp = '0);
    while (!calm && $urandom_range(0, 99) < 34) idle_cycle();
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req_sent++;
    advance_model(r);
    if (typed) begin
      if (hit) release_q.push_back(typed_rsp);
    end else begin
      foreach (due_now[i]) release_q.push_back(due_now[i]);
    end
  endtask

  task automatic wait_releases_done();
    idle_cycle();
    while (release_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_tick_step(input logic [stwq_pkg::STEP_W-1:0] v);
    wait_releases_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_step = v;
    cfg_writes++;
  endtask

  task automatic random_request(input int s);
    stwq_pkg::in_req_t r;
    int pick;
    int mode;
    pick = $urandom_range(0, 99);
    mode = $urandom_range(0, 9);
    r.task_id = stwq_pkg::ID_W'($urandom_range(0, stwq_pkg::ID_SPACE - 1));
    r.delay = $urandom;
    if (pick < 30) begin
      r.kind = stwq_pkg::KIND_TICK;
    end else if (pick < 75) begin
      r.kind = stwq_pkg::KIND_SLEEP;
      if (mode < 6) r.delay = $urandom_range(0, 3 * s + 2);
      else if (mode >= 8) r.delay = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    end else begin
      r.kind = (pick < 85) ? stwq_pkg::KIND_CANCEL : stwq_pkg::KIND_WAKE;
      if (slot_count > 0 && mode < 8) r.task_id = slot_id[$urandom_range(0, slot_count - 1)];
    end
    issue_request(r);
  endtask

  task automatic fill_and_tick(input int s);
    stwq_pkg::in_req_t r;
    for (int t = 0; t < stwq_pkg::ID_SPACE; t++) begin
      r.kind = stwq_pkg::KIND_SLEEP;
      r.task_id = stwq_pkg::ID_W'(t);
      r.delay = $urandom_range(0, s);
      issue_request(r);
    end
    r.kind = stwq_pkg::KIND_TICK;
    r.task_id = stwq_pkg::ID_W'($urandom_range(0, stwq_pkg::ID_SPACE - 1));
    r.delay = $urandom;
    issue_request(r);
  endtask

  initial begin
    int phase_steps [PHASES];
    int s;
    int n;

    model_now = '0;
    model_step = stwq_pkg::STEP_RESET;
    slot_count = 0;
    foreach (is_queued[i]) is_queued[i] = 1'b0;
    foreach (slot_id[i]) begin
      slot_id[i] = '0;
      slot_wake_ms[i] = '0;
    end

    // directed table
    plan.push_back(req_row(stwq_pkg::KIND_TICK,   0, 32'd0, 1'b1));
    plan.push_back(req_row(stwq_pkg::KIND_WAKE,   3, 32'd0, 1'b1));
    plan.push_back(req_row(stwq_pkg::KIND_CANCEL, 5, 32'd0, 1'b1));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  0, 32'd0, 1'b1));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP, 15, 32'hFFFF_FFFF, 1'b1));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  7, 32'd5));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  8, 32'd5));
    plan.push_back(req_row(stwq_pkg::KIND_WAKE,   7, 32'd0, 1'b1, 1'b1, 7));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  7, 32'd5));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  8, 32'd100));
    plan.push_back(req_row(stwq_pkg::KIND_CANCEL, 8, 32'd0, 1'b1));
    plan.push_back(req_row(stwq_pkg::KIND_TICK,   0, 32'd0));
    plan.push_back(req_row(stwq_pkg::KIND_TICK,  15, 32'hFFFF_FFFF, 1'b1));
    plan.push_back(cfg_row(10'd0));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  2, 32'd0));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  9, 32'd0));
    plan.push_back(req_row(stwq_pkg::KIND_TICK,   0, 32'd0));
    plan.push_back(cfg_row(10'd1023));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  4, 32'd2000));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  5, 32'd1023));
    plan.push_back(req_row(stwq_pkg::KIND_TICK,   0, 32'd0));
    plan.push_back(req_row(stwq_pkg::KIND_TICK,   0, 32'd0));
    plan.push_back(cfg_row(10'd1000));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP,  6, 32'h8000_0000));
    plan.push_back(req_row(stwq_pkg::KIND_SLEEP, 10, 32'd1));
    plan.push_back(req_row(stwq_pkg::KIND_WAKE,   6, 32'd0, 1'b1, 1'b1, 6));
    plan.push_back(req_row(stwq_pkg::KIND_TICK,   0, 32'd0));
    plan.push_back(cfg_row(10'd1));
    plan.push_back(req_row(stwq_pkg::KIND_TICK,   0, 32'd0, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_tick_step(plan[i].step);
      end else begin
        issue_request(plan[i].req, plan[i].typed, plan[i].typed_hit, plan[i].typed_rsp);
      end
    end

    // random phases
    phase_steps[0] = 1000;
    phase_steps[1] = 1;
    for (int p = 2; p < PHASES; p++) phase_steps[p] = $urandom_range(1, 1000);
    phase_steps[5] = 10;
    for (int p = 0; p < PHASES; p++) begin
      s = phase_steps[p];
      write_tick_step(stwq_pkg::STEP_W'(s));
      calm = (p == 3);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 4) begin
          fill_and_tick(s);
          n += stwq_pkg::ID_SPACE + 1;
        end else begin
          random_request(s);
          n++;
        end
        if ($urandom_range(0, 99) < 3) wait_releases_done();
      end
    end
    calm = 1'b0;

    wait_releases_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests and %0d releases over %0d tick_step settings",
             req_sent, rsp_seen, cfg_writes);
    $display("mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
